/* hdl/assert_macros.svh */
// assertion helpers for the rtl files, included by adc_average_to_motor_servo_pwm_unit
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ADCPWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ADCPWM_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* hdl/adcpwm_pkg.sv */
// ----------------------------------------------------------------------------
// adcpwm_pkg
// word types, stage controls and fixed scaling constants for the adc to pwm
// block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adcpwm_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int ADC_MAX    = 1023;
  localparam int SPEED_SPAN = 198;
  localparam int SPEED_HALF = 99;
  localparam int ANGLE_SPAN = 180;
  localparam int ANGLE_HALF = 90;

  localparam int AVG_W   = SAMPLE_W;
  localparam int SCALE_W = 8;
  localparam int MAG_W   = 7;
  localparam int PULSE_W = 11;
  localparam int PQ_W    = PULSE_W - 1;

  // floor(x / d) == (x * ceil(2^s / d)) >> s when x < 2^n and s = n + clog2(d)
  // the span or adc_max factor is folded into the constant

  // speed: avg * SPEED_SPAN / ADC_MAX
  localparam int SPD_X_W = $clog2(ADC_MAX * SPEED_SPAN + 1);
  localparam int SPD_SH  = SPD_X_W + $clog2(ADC_MAX);
  localparam longint unsigned SPD_MUL =
    (((64'd1 << SPD_SH) + ADC_MAX - 1) / ADC_MAX) * SPEED_SPAN;
  localparam int SPD_MUL_W = $clog2(SPD_MUL + 1);

  // angle: avg * ANGLE_SPAN / ADC_MAX
  localparam int ANG_X_W = $clog2(ADC_MAX * ANGLE_SPAN + 1);
  localparam int ANG_SH  = ANG_X_W + $clog2(ADC_MAX);
  localparam longint unsigned ANG_MUL =
    (((64'd1 << ANG_SH) + ADC_MAX - 1) / ADC_MAX) * ANGLE_SPAN;
  localparam int ANG_MUL_W = $clog2(ANG_MUL + 1);

  // motor: mag * ADC_MAX / SPEED_HALF, mag never above SPEED_HALF
  localparam int MOT_X_W = $clog2(SPEED_HALF * ADC_MAX + 1);
  localparam int MOT_SH  = MOT_X_W + $clog2(SPEED_HALF);
  localparam longint unsigned MOT_MUL =
    (((64'd1 << MOT_SH) + SPEED_HALF - 1) / SPEED_HALF) * ADC_MAX;
  localparam int MOT_MUL_W = $clog2(MOT_MUL + 1);

  // servo: angle * ADC_MAX / ANGLE_SPAN, angle never above ANGLE_SPAN
  localparam int SRV_X_W = $clog2(ANGLE_SPAN * ADC_MAX + 1);
  localparam int SRV_SH  = SRV_X_W + $clog2(ANGLE_SPAN);
  localparam longint unsigned SRV_MUL =
    (((64'd1 << SRV_SH) + ANGLE_SPAN - 1) / ANGLE_SPAN) * ADC_MAX;
  localparam int SRV_MUL_W = $clog2(SRV_MUL + 1);

  typedef struct packed {
    logic [SAMPLE_W-1:0] speed_sample;
    logic [SAMPLE_W-1:0] angle_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0]    speed_signed;
    logic [MAG_W-1:0]     speed_magnitude;
    logic                 drive_forward;
    logic                 drive_reverse;
    logic [SCALE_W-1:0]   angle_unsigned;
    logic signed [7:0]    angle_signed;
    logic [PULSE_W-1:0]   motor_pulse;
    logic [PULSE_W-1:0]   servo_pulse;
  } out_word_t;

  typedef struct packed {
    logic ld_avg;
    logic ld_scale;
    logic ld_out;
  } stage_ctrl_t;

endpackage

/* hdl/adcpwm_cell.sv */
// ----------------------------------------------------------------------------
// adcpwm_cell
// one tap of the sample window: holds a sample pair and passes it on
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adcpwm_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift_en,
  input  adcpwm_pkg::in_word_t d_word,
  output adcpwm_pkg::in_word_t q_word
);
  import adcpwm_pkg::*;

  in_word_t tap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (shift_en) begin
      tap_r <= d_word;
    end
  end

  assign q_word = tap_r;

endmodule

/* hdl/adcpwm_calc.sv */
// ----------------------------------------------------------------------------
// adcpwm_calc
// average, scale and pulse-width datapath, three register stages
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adcpwm_calc #(
  parameter int WINDOW = 10,
  parameter int SUM_W  = 14
) (
  input  logic                    clk,
  input  adcpwm_pkg::stage_ctrl_t ctrl,
  input  logic [SUM_W-1:0]        speed_sum,
  input  logic [SUM_W-1:0]        angle_sum,
  output adcpwm_pkg::out_word_t   out_word
);
  import adcpwm_pkg::*;

  // sum / WINDOW by reciprocal
  localparam int AVG_SH = SUM_W + $clog2(WINDOW);
  localparam longint unsigned AVG_MUL = ((64'd1 << AVG_SH) + WINDOW - 1) / WINDOW;
  localparam int AVG_MUL_W  = $clog2(AVG_MUL + 1);
  localparam int AVG_PROD_W = SUM_W + AVG_MUL_W;
  localparam int SPD_PROD_W = AVG_W + SPD_MUL_W;
  localparam int ANG_PROD_W = AVG_W + ANG_MUL_W;
  localparam int MOT_PROD_W = MAG_W + MOT_MUL_W;
  localparam int SRV_PROD_W = SCALE_W + SRV_MUL_W;

  logic [AVG_W-1:0]   avg_spd_r, avg_ang_r;
  logic [SCALE_W-1:0] sc_spd_r, sc_ang_r;
  out_word_t          out_r;

  logic [AVG_PROD_W-1:0] avg_spd_prod, avg_ang_prod;
  logic [SPD_PROD_W-1:0] spd_prod;
  logic [ANG_PROD_W-1:0] ang_prod;
  logic [MOT_PROD_W-1:0] mot_prod;
  logic [SRV_PROD_W-1:0] srv_prod;
  logic signed [8:0]     speed_s;
  logic [8:0]            mag_full;
  logic [MAG_W-1:0]      mag;

  // stage 1: truncated averages
  assign avg_spd_prod = speed_sum * AVG_MUL[AVG_MUL_W-1:0];
  assign avg_ang_prod = angle_sum * AVG_MUL[AVG_MUL_W-1:0];

  // stage 2: scale to span, never exceeds span since avg <= ADC_MAX
  assign spd_prod = avg_spd_r * SPD_MUL[SPD_MUL_W-1:0];
  assign ang_prod = avg_ang_r * ANG_MUL[ANG_MUL_W-1:0];

  // stage 3: signed speed, magnitude and pulse widths
  assign speed_s  = $signed({1'b0, sc_spd_r}) - $signed(9'(SPEED_HALF));
  assign mag_full = speed_s[8] ? 9'(-speed_s) : 9'(speed_s);
  assign mag      = mag_full[MAG_W-1:0];
  assign mot_prod = mag * MOT_MUL[MOT_MUL_W-1:0];
  assign srv_prod = sc_ang_r * SRV_MUL[SRV_MUL_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.ld_avg) begin
      avg_spd_r <= avg_spd_prod[AVG_SH +: AVG_W];
      avg_ang_r <= avg_ang_prod[AVG_SH +: AVG_W];
    end
    if (ctrl.ld_scale) begin
      sc_spd_r <= spd_prod[SPD_SH +: SCALE_W];
      sc_ang_r <= ang_prod[ANG_SH +: SCALE_W];
    end
    if (ctrl.ld_out) begin
      out_r.speed_signed    <= speed_s[7:0];
      out_r.speed_magnitude <= mag;
      out_r.drive_forward   <= !speed_s[8] && (speed_s != 9'sd0);
      out_r.drive_reverse   <= speed_s[8];
      out_r.angle_unsigned  <= sc_ang_r;
      out_r.angle_signed    <= sc_ang_r - SCALE_W'(ANGLE_HALF);
      out_r.motor_pulse     <= {mot_prod[MOT_SH +: PQ_W], 1'b0};
      out_r.servo_pulse     <= {srv_prod[SRV_SH +: PQ_W], 1'b0};
    end
  end

  assign out_word = out_r;

endmodule

/* hdl/adc_average_to_motor_servo_pwm_unit.sv */
// ----------------------------------------------------------------------------
// adc_average_to_motor_servo_pwm_unit
// moving average of two adc channels turned into motor drive and servo pulse
// ----------------------------------------------------------------------------
//
// channel  ports                        word
// -------  ---------------------------  ---------------------------------------
// input    in_valid  in_ready  in_word  speed and angle samples, 10 bits each
// result   out_valid out_ready out_word speed, drive bits, angle, pulse widths
//
// one word in flight: accept, average, scale, result register, so a new word
// is taken only once the previous one has left the datapath stages
// this pacing is set by the three datapath register stages in adcpwm_calc
// a result waiting in the output register does not block the next word; a
// second result waits in the last stage until out_ready
// synchronous reset clears the sample window, both sums and all valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adc_average_to_motor_servo_pwm_unit #(
  parameter int WINDOW = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  adcpwm_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output adcpwm_pkg::out_word_t out_word
);
  import adcpwm_pkg::*;

  // a full window of samples fits without overflow
  localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

  // window taps, tap[0] is the newest sample pair
  in_word_t tap [WINDOW];
  in_word_t oldest;

  logic             accept;
  logic [SUM_W-1:0] speed_sum_r, speed_sum_nxt;
  logic [SUM_W-1:0] angle_sum_r, angle_sum_nxt;

  // stage valid bits: sums updated, averages held, scaled values held
  logic        v1_r, v2_r, v3_r, out_valid_r;
  logic        v1_nxt, v2_nxt, v3_nxt, out_valid_nxt;
  stage_ctrl_t ctrl;

  assign accept = in_valid && in_ready;

  // chain of cells: each accepted word shifts the window one tap
  for (genvar k = 0; k < WINDOW; k++) begin : g_win
    if (k == 0) begin : g_head
      adcpwm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (accept),
        .d_word   (in_word),
        .q_word   (tap[k])
      );
    end else begin : g_body
      adcpwm_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (accept),
        .d_word   (tap[k-1]),
        .q_word   (tap[k])
      );
    end
  end

  // the last tap drops out of the window on this shift
  assign oldest = tap[WINDOW-1];

  // running sums: remove the oldest sample, add the new one
  always_comb begin
    speed_sum_nxt = speed_sum_r - SUM_W'(oldest.speed_sample)
                    + SUM_W'(in_word.speed_sample);
    angle_sum_nxt = angle_sum_r - SUM_W'(oldest.angle_sample)
                    + SUM_W'(in_word.angle_sample);
  end

  // stage advance: last stage waits when the output register is still full
  always_comb begin
    ctrl.ld_avg   = v1_r;
    ctrl.ld_scale = v2_r;
    ctrl.ld_out   = v3_r && (!out_valid_r || out_ready);

    v1_nxt        = accept;
    v2_nxt        = v1_r;
    v3_nxt        = v2_r || (v3_r && !ctrl.ld_out);
    out_valid_nxt = ctrl.ld_out || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_sum_r <= '0;
      angle_sum_r <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        speed_sum_r <= speed_sum_nxt;
        angle_sum_r <= angle_sum_nxt;
      end
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // averaging, scaling and pulse datapath
  adcpwm_calc #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_calc (
    .clk       (clk),
    .ctrl      (ctrl),
    .speed_sum (speed_sum_r),
    .angle_sum (angle_sum_r),
    .out_word  (out_word)
  );

  // new word only once the previous one has left the datapath stages
  assign in_ready  = !(v1_r || v2_r || v3_r);
  assign out_valid = out_valid_r;

  // only one word travels through the stages at a time
  `ADCPWM_ASSERT(a_one_in_flight, $onehot0({v1_r, v2_r, v3_r}), "two words in datapath")
  // an accepted word enters the first stage
  `ADCPWM_ASSERT(a_accept_enters, accept |=> v1_r, "accepted word lost")
  // a new result comes only from the last stage
  `ADCPWM_ASSERT(a_out_from_v3, $rose(out_valid_r) |-> $past(v3_r), "result without word")
  // h-bridge legs never driven together
  `ADCPWM_NEVER(a_drive_excl, out_valid_r && out_word.drive_forward && out_word.drive_reverse,
                "both drive bits high")

endmodule
